@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is asserted
`define ASSERT_ON(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// concurrent check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/pbr_pkg.sv @@
// shared types and constants of the projectile bounce response block
`default_nettype none

package pbr_pkg;

    localparam int LANES      = 3;
    localparam int VEL_W      = 32;
    localparam int NRM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRIC_W     = 16;
    localparam int BNC_W      = 16;
    localparam int SPD_W      = 32;
    localparam int K_W        = 9;

    // reflected velocity and its squared length
    localparam int R_W      = 46;
    localparam int MAG_W    = R_W - 1;
    localparam int SPLIT    = 32;
    localparam int HI_W     = MAG_W - SPLIT;
    localparam int SQ_W     = 2 * MAG_W + 2;
    localparam int SPD_SQ_W = 2 * SPD_W;
    localparam int BLEN_W   = $clog2(MAG_W + 1);
    localparam int SHIFT_W  = $clog2(MAG_W - 31 + 1) + 1;

    // reduced vector, root and divide
    localparam int RED_W     = 31;
    localparam int RSQ_W     = 2 * RED_W;
    localparam int NUM_W     = RED_W + SPD_W;
    localparam int ISQ_W     = 64;
    localparam int ISQ_STEPS = ISQ_W / 2;
    localparam int ROOT_W    = ISQ_W / 2;
    localparam int QUO_W     = SPD_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int REM_W     = NUM_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCINESS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED    = CFG_IDX_W'(4);

    localparam logic [BNC_W-1:0] BOUNCINESS_RESET = BNC_W'(154);

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } pbr_in_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
        logic signed [VEL_W-1:0] new_vel_z;
        logic                    stopped;
    } pbr_out_t;

    // what rides along the root and divide pipelines
    typedef struct packed {
        logic [LANES-1:0][R_W-1:0]   res;
        logic [SQ_W-1:0]             sq;
        logic                        limit;
        logic [LANES-1:0][NUM_W-1:0] num;
    } pbr_side_t;

endpackage

`default_nettype wire

@@ rtl/pbr_reflect.sv @@
// five stage pipeline: dot product, normal part, friction and restitution
`default_nettype none

module pbr_reflect import pbr_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire pbr_in_t                 in_data,
    input  wire logic [K_W-1:0]          k_in,
    input  wire logic [BNC_W-1:0]        bnc_in,
    output logic                         out_valid,
    output logic signed [R_W-1:0]        out_res [LANES]
);

    localparam int PROD_W = VEL_W + NRM_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int D_W    = 37;
    localparam int NP_W   = NRM_W + D_W;
    localparam int P_W    = 37;
    localparam int VP_W   = P_W + 1;
    localparam int VK_W   = VP_W + K_W + 1;
    localparam int PB_W   = P_W + BNC_W + 1;

    localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(1 << 13);
    localparam logic signed [NP_W-1:0]  NP_HALF  = NP_W'(1 << 13);
    localparam logic signed [VK_W-1:0]  VK_HALF  = VK_W'(1 << 7);
    localparam logic signed [PB_W-1:0]  PB_HALF  = PB_W'(1 << 7);

    logic signed [VEL_W-1:0]  vel_in [LANES];
    logic signed [NRM_W-1:0]  nrm_in [LANES];

    // stage 1
    logic                     vld1_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [VEL_W-1:0]  vel1_reg [LANES];
    logic signed [NRM_W-1:0]  nrm1_reg [LANES];
    // stage 2
    logic                     vld2_reg;
    logic                     neg2_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [VEL_W-1:0]  vel2_reg [LANES];
    logic signed [NRM_W-1:0]  nrm2_reg [LANES];
    // stage 3
    logic                     vld3_reg;
    logic                     neg3_reg;
    logic signed [NP_W-1:0]   np_reg   [LANES];
    logic signed [VEL_W-1:0]  vel3_reg [LANES];
    // stage 4
    logic                     vld4_reg;
    logic                     neg4_reg;
    logic signed [VK_W-1:0]   vk_reg   [LANES];
    logic signed [PB_W-1:0]   pb_reg   [LANES];
    logic signed [VEL_W-1:0]  vel4_reg [LANES];
    // stage 5
    logic                     vld5_reg;
    logic signed [R_W-1:0]    res_reg  [LANES];

    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  dot_neg;
    logic signed [D_W-1:0]    d_next;
    logic signed [P_W-1:0]    p_val  [LANES];
    logic signed [VP_W-1:0]   vp_val [LANES];
    logic signed [VK_W-1:0]   t_full [LANES];
    logic signed [PB_W-1:0]   b_full [LANES];
    logic signed [R_W-1:0]    res_next [LANES];

    always_comb begin
        vel_in[0] = in_data.vel_x;
        vel_in[1] = in_data.vel_y;
        vel_in[2] = in_data.vel_z;
        nrm_in[0] = in_data.normal_x;
        nrm_in[1] = in_data.normal_y;
        nrm_in[2] = in_data.normal_z;
    end

    // d = round(-dot / 2^14), only meaningful when the item approaches
    always_comb begin
        dot     = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        dot_neg = -dot;
        d_next  = D_W'((dot_neg + DOT_HALF) >>> 14);
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            p_val[i]    = P_W'((np_reg[i] + NP_HALF) >>> 14);
            vp_val[i]   = VP_W'(vel3_reg[i]) + VP_W'(p_val[i]);
            t_full[i]   = (vk_reg[i] + VK_HALF) >>> 8;
            b_full[i]   = (pb_reg[i] + PB_HALF) >>> 8;
            res_next[i] = neg4_reg ? R_W'(t_full[i]) + R_W'(b_full[i])
                                   : R_W'(vel4_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                prod_reg[i] <= vel_in[i] * nrm_in[i];
                vel1_reg[i] <= vel_in[i];
                nrm1_reg[i] <= nrm_in[i];
                vel2_reg[i] <= vel1_reg[i];
                nrm2_reg[i] <= nrm1_reg[i];
                np_reg[i]   <= nrm2_reg[i] * d_reg;
                vel3_reg[i] <= vel2_reg[i];
                vk_reg[i]   <= vp_val[i] * $signed({1'b0, k_in});
                pb_reg[i]   <= p_val[i] * $signed({1'b0, bnc_in});
                vel4_reg[i] <= vel3_reg[i];
                res_reg[i]  <= res_next[i];
            end
            d_reg    <= d_next;
            neg2_reg <= dot[DOT_W-1];
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
        end
    end

    assign out_valid = vld5_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            out_res[i] = res_reg[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbr_isqrt.sv @@
// pipelined integer square root, one result bit per stage
`default_nettype none

module pbr_isqrt import pbr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [ISQ_W-1:0]  in_rad,
    input  wire pbr_side_t         in_side,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      out_root,
    output pbr_side_t              out_side
);

    logic              vld_reg  [ISQ_STEPS];
    logic [ISQ_W-1:0]  rad_reg  [ISQ_STEPS];
    logic [ISQ_W-1:0]  root_reg [ISQ_STEPS];
    pbr_side_t         side_reg [ISQ_STEPS];

    for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (ISQ_W - 2 - 2 * j);

        logic             vld_in;
        logic [ISQ_W-1:0] rad_in;
        logic [ISQ_W-1:0] root_in;
        pbr_side_t        side_in;
        logic [ISQ_W-1:0] trial;
        logic [ISQ_W-1:0] rad_next;
        logic [ISQ_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb begin
            trial = root_in + BIT;
            if (rad_in >= trial) begin
                rad_next  = rad_in - trial;
                root_next = (root_in >> 1) + BIT;
            end else begin
                rad_next  = rad_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j]  <= rad_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ISQ_STEPS-1];
    assign out_root  = root_reg[ISQ_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[ISQ_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/pbr_div.sv @@
// pipelined restoring divider, three lanes sharing one divisor
`default_nettype none

module pbr_div import pbr_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [ROOT_W-1:0]  in_div,
    input  wire pbr_side_t          in_side,
    output logic                    out_valid,
    output logic [QUO_W-1:0]        out_quo [LANES],
    output pbr_side_t               out_side
);

    logic              vld_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] div_reg  [DIV_STEPS];
    logic [REM_W-1:0]  rem_reg  [DIV_STEPS][LANES];
    logic [QUO_W-1:0]  quo_reg  [DIV_STEPS][LANES];
    pbr_side_t         side_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int BITI = QUO_W - 1 - j;

        logic              vld_in;
        logic [ROOT_W-1:0] div_in;
        pbr_side_t         side_in;
        logic [REM_W-1:0]  rem_in    [LANES];
        logic [QUO_W-1:0]  quo_in    [LANES];
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  rem_next  [LANES];
        logic [QUO_W-1:0]  quo_next  [LANES];

        if (j == 0) begin : g_first
            assign vld_in  = in_valid;
            assign div_in  = in_div;
            assign side_in = in_side;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = REM_W'(in_side.num[l]);
                    quo_in[l] = '0;
                end
            end
        end else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign div_in  = div_reg[j-1];
            assign side_in = side_reg[j-1];
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = rem_reg[j-1][l];
                    quo_in[l] = quo_reg[j-1][l];
                end
            end
        end

        always_comb begin
            shifted = REM_W'(div_in) << BITI;
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= shifted) begin
                    rem_next[l] = rem_in[l] - shifted;
                    quo_next[l] = quo_in[l] | (QUO_W'(1) << BITI);
                end else begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[j]  <= div_in;
                side_reg[j] <= side_in;
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[j][l] <= rem_next[l];
                    quo_reg[j][l] <= quo_next[l];
                end
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l] = quo_reg[DIV_STEPS-1][l];
        end
    end

endmodule

`default_nettype wire

@@ rtl/projectile_bounce_response.sv @@
// top level of the projectile bounce response block
//
// s_ channel: one impact per beat (velocity Q16.16 per axis, unit normal Q2.14).
// m_ channel: one result beat per impact (new velocity, saturated, plus stopped).
// cfg_we/cfg_addr/cfg_wdata: register writes, taken at any edge with cfg_we high;
//   write only while no impact is in flight.
// pipeline from the accepting edge to m_valid: 5 reflect stages,
//   3 length stages, 32 root stages, 32 divide stages, 1 rescale stage,
//   1 output register.
// throughput: one beat per cycle when not stalled; up to 74 beats in flight.
// stall: the whole pipeline advances only when the output register is empty or
//   being taken, so s_ready drops in the same cycle a full output is held;
//   nothing is dropped or repeated.
// reset: aresetn low clears all valid bits and loads the register defaults
//   (bounce off, friction 0, bounciness 154, no speed limit, no stop speed).
`default_nettype none

module projectile_bounce_response import pbr_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pbr_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pbr_out_t                   m_data
);

    // configuration registers
    logic                  bounce_enable_reg;
    logic [FRIC_W-1:0]     friction_reg;
    logic [BNC_W-1:0]      bounciness_reg;
    logic [SPD_W-1:0]      max_speed_reg;
    logic [SPD_W-1:0]      stop_speed_reg;
    logic [SPD_SQ_W-1:0]   mx_sq_reg;
    logic [SPD_SQ_W-1:0]   st_sq_reg;
    logic [K_W-1:0]        k_val;

    // pipeline advance: the output register is free or being drained
    logic                  en;

    // reflect output
    logic                  rf_valid;
    logic signed [R_W-1:0] rf_res [LANES];

    // length stage 1: partial squares and reduced vector
    logic                    l1_vld_reg;
    logic [2*HI_W-1:0]       hh_reg  [LANES];
    logic [HI_W+SPLIT-1:0]   hl_reg  [LANES];
    logic [2*SPLIT-1:0]      ll_reg  [LANES];
    logic [RED_W-1:0]        red_reg [LANES];
    logic signed [R_W-1:0]   l1_res_reg [LANES];
    logic [MAG_W-1:0]        mag   [LANES];
    logic [MAG_W-1:0]        mag_or;
    logic [BLEN_W-1:0]       blen;
    logic [SHIFT_W-1:0]      red_shift;

    // length stage 2: full squared length, reduced squares, numerators
    logic                    l2_vld_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [RSQ_W-1:0]        rsq_reg [LANES];
    logic [NUM_W-1:0]        num_reg [LANES];
    logic signed [R_W-1:0]   l2_res_reg [LANES];
    logic [SQ_W-1:0]         sq_next;

    // length stage 3: limit decision and radicand
    logic                    l3_vld_reg;
    logic [ISQ_W-1:0]        rad_reg;
    pbr_side_t               l3_side_reg;
    logic [ISQ_W-1:0]        rad_next;
    pbr_side_t               l3_side_next;

    // root and divide
    logic                    sr_valid;
    logic [ROOT_W-1:0]       sr_root;
    pbr_side_t               sr_side;
    logic                    dv_valid;
    logic [QUO_W-1:0]        dv_quo [LANES];
    pbr_side_t               dv_side;

    // rescale stage
    logic                    f1_vld_reg;
    logic                    f1_limit_reg;
    logic [SQ_W-1:0]         f1_sq_reg;
    logic [2*QUO_W-1:0]      msq_reg [LANES];
    logic signed [R_W-1:0]   vfin_reg [LANES];
    logic signed [R_W-1:0]   quo_ext [LANES];
    logic signed [R_W-1:0]   vfin_next [LANES];

    // output register
    logic                    m_valid_reg;
    pbr_out_t                m_data_reg;
    pbr_out_t                m_data_next;
    logic [SQ_W-1:0]         fsq;
    logic                    stop;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [R_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        begin
            if (v[R_W-1:VEL_W-1] == '0 || v[R_W-1:VEL_W-1] == '1) begin
                r = v[VEL_W-1:0];
            end else if (v[R_W-1]) begin
                r = {1'b1, {(VEL_W-1){1'b0}}};
            end else begin
                r = {1'b0, {(VEL_W-1){1'b1}}};
            end
            return r;
        end
    endfunction

    // register writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounce_enable_reg <= 1'b0;
            friction_reg      <= '0;
            bounciness_reg    <= BOUNCINESS_RESET;
            max_speed_reg     <= '0;
            stop_speed_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BOUNCE_ENABLE: bounce_enable_reg <= cfg_wdata[0];
                CFG_FRICTION:      friction_reg      <= cfg_wdata[FRIC_W-1:0];
                CFG_BOUNCINESS:    bounciness_reg    <= cfg_wdata[BNC_W-1:0];
                CFG_MAX_SPEED:     max_speed_reg     <= cfg_wdata[SPD_W-1:0];
                CFG_STOP_SPEED:    stop_speed_reg    <= cfg_wdata[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // squared limits; user keeps config static while beats fly, not enforced
    always_ff @(posedge aclk) begin
        mx_sq_reg <= max_speed_reg * max_speed_reg;
        st_sq_reg <= stop_speed_reg * stop_speed_reg;
    end

    // tangential scale: 256 - friction, zero once friction reaches one
    assign k_val = (friction_reg[FRIC_W-1:8] != '0) ? '0
                 : K_W'(9'd256 - {1'b0, friction_reg[7:0]});

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    pbr_reflect u_reflect (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .k_in      (k_val),
        .bnc_in    (bounciness_reg),
        .out_valid (rf_valid),
        .out_res   (rf_res)
    );

    // magnitudes split 13/32 so each square is at most 32x32; the reduction
    // shift is the smallest that brings every magnitude below 2^31
    always_comb begin
        mag_or = '0;
        for (int i = 0; i < LANES; i++) begin
            mag[i] = rf_res[i][R_W-1] ? MAG_W'(-rf_res[i]) : MAG_W'(rf_res[i]);
            mag_or = mag_or | mag[i];
        end
        blen = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mag_or[b]) begin
                blen = BLEN_W'(b + 1);
            end
        end
        red_shift = (blen > BLEN_W'(RED_W)) ? SHIFT_W'(blen - BLEN_W'(RED_W)) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                hh_reg[i]     <= mag[i][MAG_W-1:SPLIT] * mag[i][MAG_W-1:SPLIT];
                hl_reg[i]     <= mag[i][MAG_W-1:SPLIT] * mag[i][SPLIT-1:0];
                ll_reg[i]     <= mag[i][SPLIT-1:0] * mag[i][SPLIT-1:0];
                red_reg[i]    <= RED_W'(mag[i] >> red_shift);
                l1_res_reg[i] <= rf_res[i];
            end
        end
    end

    // exact |R|^2 from the partial squares
    always_comb begin
        sq_next = '0;
        for (int i = 0; i < LANES; i++) begin
            sq_next = sq_next + (SQ_W'(hh_reg[i]) << (2 * SPLIT))
                              + (SQ_W'(hl_reg[i]) << (SPLIT + 1))
                              + SQ_W'(ll_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
            for (int i = 0; i < LANES; i++) begin
                rsq_reg[i]    <= red_reg[i] * red_reg[i];
                num_reg[i]    <= red_reg[i] * max_speed_reg;
                l2_res_reg[i] <= l1_res_reg[i];
            end
        end
    end

    // limit only when a speed cap is set and the squared length exceeds it
    always_comb begin
        rad_next = '0;
        for (int i = 0; i < LANES; i++) begin
            rad_next                 = rad_next + ISQ_W'(rsq_reg[i]);
            l3_side_next.res[i]      = l2_res_reg[i];
            l3_side_next.num[i]      = num_reg[i];
        end
        l3_side_next.sq    = sq_reg;
        l3_side_next.limit = (max_speed_reg != '0) && (sq_reg > SQ_W'(mx_sq_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg     <= rad_next;
            l3_side_reg <= l3_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_vld_reg <= 1'b0;
            l2_vld_reg <= 1'b0;
            l3_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            l1_vld_reg <= rf_valid;
            l2_vld_reg <= l1_vld_reg;
            l3_vld_reg <= l2_vld_reg;
            f1_vld_reg <= dv_valid;
        end
    end

    pbr_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (l3_vld_reg),
        .in_rad    (rad_reg),
        .in_side   (l3_side_reg),
        .out_valid (sr_valid),
        .out_root  (sr_root),
        .out_side  (sr_side)
    );

    // a limited vector is never all zero, so the root is nonzero there
    pbr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sr_valid),
        .in_div    (sr_root),
        .in_side   (sr_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // rescaled component keeps the sign of the reflected one
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            quo_ext[i]   = R_W'(dv_quo[i]);
            vfin_next[i] = !dv_side.limit ? $signed(dv_side.res[i])
                         : (dv_side.res[i][R_W-1] ? -quo_ext[i] : quo_ext[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_limit_reg <= dv_side.limit;
            f1_sq_reg    <= dv_side.sq;
            for (int i = 0; i < LANES; i++) begin
                msq_reg[i]  <= dv_quo[i] * dv_quo[i];
                vfin_reg[i] <= vfin_next[i];
            end
        end
    end

    // stop test on the final vector, then saturate
    always_comb begin
        fsq = f1_limit_reg ? SQ_W'(msq_reg[0]) + SQ_W'(msq_reg[1]) + SQ_W'(msq_reg[2])
                           : f1_sq_reg;
        stop = !bounce_enable_reg || (fsq < SQ_W'(st_sq_reg));
        m_data_next.new_vel_x = stop ? '0 : sat_vel(vfin_reg[0]);
        m_data_next.new_vel_y = stop ? '0 : sat_vel(vfin_reg[1]);
        m_data_next.new_vel_z = stop ? '0 : sat_vel(vfin_reg[2]);
        m_data_next.stopped   = stop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/pbr_checker.sv @@
// port level checks of the projectile bounce response block and their bind
`default_nettype none

`include "assert_macros.svh"

module pbr_checker import pbr_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_we,
    input wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire pbr_in_t               s_data,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire pbr_out_t              m_data
);

    logic cfg_seen;
    logic in_seen;

    assign cfg_seen = cfg_we && (cfg_addr != '0 || cfg_wdata != '0);
    assign in_seen  = s_valid && (s_data != '0);

    // reset empties the output register
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "m_valid survived reset")

    // input side opens exactly when the output is free or draining
    `ASSERT_ON(a_ready_tracks_out, aclk, aresetn, s_ready == (!m_valid || m_ready), "s_ready does not follow the output stall")

    // a held result keeps its value
    `ASSERT_ON(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "held result changed")

    // a stopped projectile has zero velocity
    `ASSERT_ON(a_stop_zero, aclk, aresetn, m_valid && m_data.stopped && (cfg_seen || in_seen || !cfg_seen) |-> m_data.new_vel_x == '0 && m_data.new_vel_y == '0 && m_data.new_vel_z == '0, "stopped with nonzero velocity")

endmodule

bind projectile_bounce_response pbr_checker u_pbr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

`default_nettype wire
